// File: design/pair_key_chained_hash_map_core_macros.svh
// assertion macros for the pair key chained hash map core
// used by the checker module, no other dependencies
`ifndef PAIR_KEY_CHAINED_HASH_MAP_CORE_MACROS_SVH
`define PAIR_KEY_CHAINED_HASH_MAP_CORE_MACROS_SVH

// implication checked at every rising edge outside reset
`define PKCHM_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pkchm assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define PKCHM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pkchm assertion failed");

`endif

// File: design/pkchm_pkg.sv
// shared types and constants for the pair key chained hash map core
// no dependencies
`timescale 1ns / 1ps

package pkchm_pkg;

    // default sizing
    localparam int DEF_BUCKET_BITS = 10;
    localparam int DEF_ENTRY_COUNT = 1024;
    localparam int DEF_KEY_BITS    = 20;

    // fixed field widths
    localparam int FIELD_KEY_W = 20;
    localparam int VALUE_W     = 32;
    localparam int FUNC_W      = 2;

    // value returned on a miss or a dropped append
    localparam logic signed [VALUE_W-1:0] MISS_VALUE = -32'sd1;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_UPSERT = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_INSERT = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

endpackage

// File: design/pair_key_chained_hash_map_core.sv
// flow: a clear goes from accept through ST_OUT to result valid; other operations go
// through ST_HEAD, then ST_ENTRY once per chain entry read (none for an empty bucket,
// at most one for insert), then ST_OUT; one transaction at a time, and the chain walk
// through the entry ram reads one entry per cycle
// reset: synchronous, active low; then a pass that writes the null index to each of
// the 2^BUCKET_BITS heads, with s_ready low
`timescale 1ns / 1ps

module pair_key_chained_hash_map_core #(
    parameter int BUCKET_BITS = pkchm_pkg::DEF_BUCKET_BITS,
    parameter int ENTRY_COUNT = pkchm_pkg::DEF_ENTRY_COUNT,
    parameter int KEY_BITS    = pkchm_pkg::DEF_KEY_BITS
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic [pkchm_pkg::FUNC_W-1:0]              s_func,
    input  logic [pkchm_pkg::FIELD_KEY_W-1:0]         s_key_first,
    input  logic [pkchm_pkg::FIELD_KEY_W-1:0]         s_key_second,
    input  logic signed [pkchm_pkg::VALUE_W-1:0]      s_new_value,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic signed [pkchm_pkg::VALUE_W-1:0]      m_result_value,
    output logic                                      m_hit,
    output logic                                      m_table_full
);

    localparam int KW     = pkchm_pkg::FIELD_KEY_W;
    localparam int VW     = pkchm_pkg::VALUE_W;
    localparam int IDX_W  = $clog2(ENTRY_COUNT + 1);
    localparam int EA_W   = $clog2(ENTRY_COUNT);
    localparam int HASH_W = KW + 6;
    localparam int ENT_W  = BUCKET_BITS + 2 * KW + VW + IDX_W;
    localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(ENTRY_COUNT);
    localparam logic [KW-1:0] KEY_MASK =
        (KEY_BITS >= KW) ? {KW{1'b1}} : KW'((64'd1 << KEY_BITS) - 64'd1);

    typedef enum logic [2:0] {
        ST_INIT, ST_IDLE, ST_HEAD, ST_ENTRY, ST_OUT
    } state_t;

    state_t                   state_reg;
    logic [BUCKET_BITS-1:0]   init_cnt_reg;
    logic [IDX_W-1:0]         used_reg;
    pkchm_pkg::func_t         func_reg;
    logic [KW-1:0]            a_reg;
    logic [KW-1:0]            b_reg;
    logic signed [VW-1:0]     v_reg;
    logic [BUCKET_BITS-1:0]   bkt_reg;
    logic [IDX_W-1:0]         head_reg;
    logic [IDX_W-1:0]         cur_idx_reg;
    logic                     first_reg;
    logic signed [VW-1:0]     res_value_reg;
    logic                     res_hit_reg;
    logic                     res_full_reg;
    logic                     m_valid_reg;
    logic signed [VW-1:0]     m_result_value_reg;
    logic                     m_hit_reg;
    logic                     m_table_full_reg;

    // input key masking and bucket hash (first * 31 + second)
    logic [KW-1:0]          key_a;
    logic [KW-1:0]          key_b;
    logic [HASH_W-1:0]      hash_sum;
    logic [BUCKET_BITS-1:0] bucket_in;
    pkchm_pkg::func_t       func_in;

    assign key_a     = s_key_first & KEY_MASK;
    assign key_b     = s_key_second & KEY_MASK;
    assign hash_sum  = {1'b0, key_a, 5'b0} - HASH_W'(key_a) + HASH_W'(key_b);
    assign bucket_in = hash_sum[BUCKET_BITS-1:0];
    assign func_in   = pkchm_pkg::func_t'(s_func);

    // memory ports
    logic                   hd_wr_en;
    logic [BUCKET_BITS-1:0] hd_wr_addr;
    logic [IDX_W-1:0]       hd_wr_data;
    logic                   hd_rd_en;
    logic [BUCKET_BITS-1:0] hd_rd_addr;
    logic [IDX_W-1:0]       hd_rd_data;
    logic                   ent_wr_en;
    logic [EA_W-1:0]        ent_wr_addr;
    logic [ENT_W-1:0]       ent_wr_data;
    logic                   ent_rd_en;
    logic [IDX_W-1:0]       ent_rd_idx;
    logic [ENT_W-1:0]       ent_rd_data;

    pkchm_ram #(.WIDTH(IDX_W), .DEPTH(2 ** BUCKET_BITS)) u_head_ram (
        .aclk    (aclk),
        .wr_en   (hd_wr_en),
        .wr_addr (hd_wr_addr),
        .wr_data (hd_wr_data),
        .rd_en   (hd_rd_en),
        .rd_addr (hd_rd_addr),
        .rd_data (hd_rd_data)
    );

    pkchm_ram #(.WIDTH(ENT_W), .DEPTH(ENTRY_COUNT)) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (ent_wr_data),
        .rd_en   (ent_rd_en),
        .rd_addr (ent_rd_idx[EA_W-1:0]),
        .rd_data (ent_rd_data)
    );

    // entry word fields
    logic [BUCKET_BITS-1:0] ent_bkt;
    logic [KW-1:0]          ent_first;
    logic [KW-1:0]          ent_second;
    logic [VW-1:0]          ent_value;
    logic [IDX_W-1:0]       ent_link;

    assign {ent_bkt, ent_first, ent_second, ent_value, ent_link} = ent_rd_data;

    // chain decisions; a head is live only if below the fill count and its entry
    // belongs to this bucket, which makes stale heads after a clear harmless
    logic             can_append;
    logic             chain_empty;
    logic             bad_head;
    logic             key_match;
    logic             next_null;
    logic             append_go;
    logic             append_ok;
    logic [IDX_W-1:0] append_link;
    logic             fin;
    logic signed [VW-1:0] fin_value;
    logic             fin_hit;
    logic             fin_full;

    assign can_append  = (used_reg != NULL_IDX);
    assign chain_empty = (hd_rd_data >= used_reg);
    assign bad_head    = first_reg && (ent_bkt != bkt_reg);
    assign key_match   = !bad_head && (ent_first == a_reg) && (ent_second == b_reg);
    assign next_null   = (ent_link >= used_reg);
    assign append_link = (state_reg == ST_HEAD || bad_head) ? NULL_IDX : head_reg;
    assign append_ok   = append_go && can_append;

    // memory control and finishing result
    always_comb begin
        hd_wr_en    = 1'b0;
        hd_wr_addr  = bkt_reg;
        hd_wr_data  = used_reg;
        hd_rd_en    = 1'b0;
        hd_rd_addr  = bucket_in;
        ent_wr_en   = 1'b0;
        ent_wr_addr = used_reg[EA_W-1:0];
        ent_wr_data = {bkt_reg, a_reg, b_reg, v_reg, append_link};
        ent_rd_en   = 1'b0;
        ent_rd_idx  = hd_rd_data;
        append_go   = 1'b0;
        fin         = 1'b0;
        fin_value   = pkchm_pkg::MISS_VALUE;
        fin_hit     = 1'b0;
        fin_full    = 1'b0;
        case (state_reg)
            ST_INIT: begin
                hd_wr_en   = 1'b1;
                hd_wr_addr = init_cnt_reg;
                hd_wr_data = NULL_IDX;
            end
            ST_IDLE: begin
                if (s_valid && func_in == pkchm_pkg::FUNC_CLEAR) begin
                    fin       = 1'b1;
                    fin_value = '0;
                end else begin
                    hd_rd_en = s_valid;
                end
            end
            ST_HEAD: begin
                if (!chain_empty) begin
                    ent_rd_en  = 1'b1;
                    ent_rd_idx = hd_rd_data;
                end else if (func_reg == pkchm_pkg::FUNC_LOOKUP) begin
                    fin = 1'b1;
                end else begin
                    append_go = 1'b1;
                end
            end
            ST_ENTRY: begin
                if (func_reg == pkchm_pkg::FUNC_INSERT) begin
                    append_go = 1'b1;
                end else if (key_match) begin
                    fin     = 1'b1;
                    fin_hit = 1'b1;
                    if (func_reg == pkchm_pkg::FUNC_UPSERT) begin
                        fin_value   = v_reg;
                        ent_wr_en   = 1'b1;
                        ent_wr_addr = cur_idx_reg[EA_W-1:0];
                        ent_wr_data = {ent_bkt, a_reg, b_reg, v_reg, ent_link};
                    end else begin
                        fin_value = ent_value;
                    end
                end else if (bad_head || next_null) begin
                    if (func_reg == pkchm_pkg::FUNC_LOOKUP) begin
                        fin = 1'b1;
                    end else begin
                        append_go = 1'b1;
                    end
                end else begin
                    ent_rd_en  = 1'b1;
                    ent_rd_idx = ent_link;
                end
            end
            default: begin
            end
        endcase
        // prepend a new entry at the fill count
        if (append_go) begin
            fin = 1'b1;
            if (can_append) begin
                hd_wr_en  = 1'b1;
                ent_wr_en = 1'b1;
                fin_value = v_reg;
            end else begin
                fin_full = 1'b1;
            end
        end
    end

    // sequencer state, counters and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            init_cnt_reg <= '0;
            used_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            if (ent_rd_en) begin
                cur_idx_reg <= ent_rd_idx;
            end
            if (append_ok) begin
                used_reg <= used_reg + 1'b1;
            end
            if (fin) begin
                res_value_reg <= fin_value;
                res_hit_reg   <= fin_hit;
                res_full_reg  <= fin_full;
            end
            case (state_reg)
                ST_INIT: begin
                    init_cnt_reg <= init_cnt_reg + 1'b1;
                    if (init_cnt_reg == {BUCKET_BITS{1'b1}}) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        func_reg  <= func_in;
                        a_reg     <= key_a;
                        b_reg     <= key_b;
                        v_reg     <= s_new_value;
                        bkt_reg   <= bucket_in;
                        first_reg <= 1'b1;
                        if (func_in == pkchm_pkg::FUNC_CLEAR) begin
                            used_reg  <= '0;
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_HEAD;
                        end
                    end
                end
                ST_HEAD: begin
                    head_reg  <= hd_rd_data;
                    state_reg <= fin ? ST_OUT : ST_ENTRY;
                end
                ST_ENTRY: begin
                    first_reg <= 1'b0;
                    if (fin) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg        <= 1'b1;
                        m_result_value_reg <= res_value_reg;
                        m_hit_reg          <= res_hit_reg;
                        m_table_full_reg   <= res_full_reg;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_value_reg;
    assign m_hit          = m_hit_reg;
    assign m_table_full   = m_table_full_reg;

endmodule

// File: design/pkchm_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module pkchm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/pkchm_checker.sv
// port level checker for the pair key chained hash map core, with its bind
// depends on pkchm_pkg and the macros header
`timescale 1ns / 1ps
`include "pair_key_chained_hash_map_core_macros.svh"

module pkchm_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [pkchm_pkg::VALUE_W-1:0] m_result_value,
    input logic                                 m_hit,
    input logic                                 m_table_full
);

    // a stalled result transaction stays offered
    `PKCHM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)

    // one transaction in work at a time
    `PKCHM_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready)

    // a dropped append is never a hit
    `PKCHM_ASSERT_IMPL(a_full_not_hit, aclk, aresetn, m_valid && m_table_full, !m_hit)

    // a dropped append returns the miss value
    `PKCHM_ASSERT_IMPL(a_full_value, aclk, aresetn, m_valid && m_table_full,
        m_result_value == pkchm_pkg::MISS_VALUE)

endmodule

bind pair_key_chained_hash_map_core pkchm_checker u_pkchm_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_value (m_result_value),
    .m_hit          (m_hit),
    .m_table_full   (m_table_full)
);

// File: verif/pair_key_chained_hash_map_core_checker.sv
// result checker for the pair key chained hash map core: mirrors the table
// and compares each result transaction against its prediction; uses pkchm_pkg
`timescale 1ns / 1ps

module pair_key_chained_hash_map_core_checker
    import pkchm_pkg::*;
#(
    parameter int BUCKET_BITS = DEF_BUCKET_BITS,
    parameter int ENTRY_COUNT = DEF_ENTRY_COUNT,
    parameter int KEY_BITS    = DEF_KEY_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [FUNC_W-1:0]             s_func,
    input  logic [FIELD_KEY_W-1:0]        s_key_first,
    input  logic [FIELD_KEY_W-1:0]        s_key_second,
    input  logic signed [VALUE_W-1:0]     s_new_value,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic signed [VALUE_W-1:0]     m_result_value,
    input  logic                          m_hit,
    input  logic                          m_table_full,
    output int                            fail_count,
    output int                            pending_count
);

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      hit;
        logic                      full;
    } lookup_result_t;

    localparam int NUM_BUCKETS = 1 << BUCKET_BITS;

    // mirror of the table
    int unsigned head_idx [NUM_BUCKETS];
    int unsigned ent_first [ENTRY_COUNT];
    int unsigned ent_second [ENTRY_COUNT];
    logic [VALUE_W-1:0] ent_value [ENTRY_COUNT];
    int unsigned ent_link [ENTRY_COUNT];
    int unsigned used_count;
    lookup_result_t expected_q[$];

    function automatic void wipe_table();
        for (int i = 0; i < NUM_BUCKETS; i++) head_idx[i] = ENTRY_COUNT;
        used_count = 0;
    endfunction

    // walk the chain, return the index holding the key or the null index
    function automatic int unsigned find_entry(int unsigned bkt, int unsigned a, int unsigned b);
        int unsigned idx;
        int unsigned steps;
        idx = head_idx[bkt];
        steps = 0;
        while (idx < ENTRY_COUNT && steps < ENTRY_COUNT) begin
            if (ent_first[idx] == a && ent_second[idx] == b) return idx;
            idx = ent_link[idx];
            steps++;
        end
        return ENTRY_COUNT;
    endfunction

    function automatic bit prepend_entry(int unsigned bkt, int unsigned a, int unsigned b,
                                         logic [VALUE_W-1:0] v);
        if (used_count >= ENTRY_COUNT) return 0;
        ent_first[used_count] = a;
        ent_second[used_count] = b;
        ent_value[used_count] = v;
        ent_link[used_count] = head_idx[bkt];
        head_idx[bkt] = used_count;
        used_count++;
        return 1;
    endfunction

    function automatic lookup_result_t apply_operation(func_t op, logic [FIELD_KEY_W-1:0] kf,
                                                       logic [FIELD_KEY_W-1:0] ks,
                                                       logic [VALUE_W-1:0] v);
        lookup_result_t r;
        int unsigned a, b, bkt, idx;
        longint unsigned mix;
        a = kf & ((1 << KEY_BITS) - 1);
        b = ks & ((1 << KEY_BITS) - 1);
        mix = longint'(a) * 31 + longint'(b);
        bkt = 32'(mix & (NUM_BUCKETS - 1));
        r = '0;
        case (op)
            FUNC_UPSERT: begin
                idx = find_entry(bkt, a, b);
                if (idx != ENTRY_COUNT) begin
                    ent_value[idx] = v;
                    r.value = v;
                    r.hit = 1;
                end else if (prepend_entry(bkt, a, b, v)) begin
                    r.value = v;
                end else begin
                    r.value = MISS_VALUE;
                    r.full = 1;
                end
            end
            FUNC_LOOKUP: begin
                idx = find_entry(bkt, a, b);
                if (idx != ENTRY_COUNT) begin
                    r.value = ent_value[idx];
                    r.hit = 1;
                end else begin
                    r.value = MISS_VALUE;
                end
            end
            FUNC_INSERT: begin
                if (prepend_entry(bkt, a, b, v)) begin
                    r.value = v;
                end else begin
                    r.value = MISS_VALUE;
                    r.full = 1;
                end
            end
            default: wipe_table();
        endcase
        return r;
    endfunction

    initial begin
        fail_count = 0;
        wipe_table();
    end

    assign pending_count = expected_q.size();

    // predict on input transactions, compare on result transactions
    always @(posedge aclk) begin
        lookup_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want = apply_operation(func_t'(s_func), s_key_first, s_key_second,
                                       s_new_value);
                expected_q.insert(expected_q.size(), want);
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result value %0d hit %0b full %0b", $time,
                             m_result_value, m_hit, m_table_full);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (want.value !== m_result_value) begin
                        $display("%0t: result_value expected %0d actual %0d", $time,
                                 want.value, m_result_value);
                        fail_count++;
                    end
                    if (want.hit !== m_hit) begin
                        $display("%0t: hit expected %0b actual %0b", $time, want.hit, m_hit);
                        fail_count++;
                    end
                    if (want.full !== m_table_full) begin
                        $display("%0t: table_full expected %0b actual %0b", $time,
                                 want.full, m_table_full);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// File: verif/pair_key_chained_hash_map_core_tb.sv
// stimulus and verdict for the pair key chained hash map core
// depends on pkchm_pkg, the core and pair_key_chained_hash_map_core_checker
`timescale 1ns / 1ps

module pair_key_chained_hash_map_core_tb;
    import pkchm_pkg::*;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [FUNC_W-1:0] s_func = FUNC_LOOKUP;
    logic [FIELD_KEY_W-1:0] s_key_first = '0;
    logic [FIELD_KEY_W-1:0] s_key_second = '0;
    logic signed [VALUE_W-1:0] s_new_value = '0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [VALUE_W-1:0] m_result_value;
    logic m_hit;
    logic m_table_full;
    int fail_count;
    int pending_count;

    int send_idle_pct = 6;
    int recv_idle_pct = 54;
    int hold_off_cycles = 0;
    logic hold_off_req = 0;
    logic hold_off_ack = 0;

    // keys sent earlier (up to 64 since the last clear) so lookups and upserts hit
    logic [FIELD_KEY_W-1:0] used_first[$];
    logic [FIELD_KEY_W-1:0] used_second[$];

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    pair_key_chained_hash_map_core dut (.*);

    pair_key_chained_hash_map_core_checker checker_inst (.*);

    // receiver readiness, with one long hold-off during the fill phase
    always @(posedge aclk) begin
        if (hold_off_req != hold_off_ack) begin
            hold_off_ack <= hold_off_req;
            hold_off_cycles <= 300;
            m_ready <= 0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one transaction and wait until it is taken
    task automatic send_op(func_t op, logic [FIELD_KEY_W-1:0] kf,
                           logic [FIELD_KEY_W-1:0] ks, logic [VALUE_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_func <= op;
        s_key_first <= kf;
        s_key_second <= ks;
        s_new_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op != FUNC_CLEAR && used_first.size() < 64) begin
            used_first.insert(used_first.size(), kf);
            used_second.insert(used_second.size(), ks);
        end
    endtask

    task automatic drain_results();
        s_valid <= 0;
        while (pending_count != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic random_op();
        int sel, k;
        logic [FIELD_KEY_W-1:0] kf, ks;
        sel = $urandom_range(99);
        kf = FIELD_KEY_W'($urandom);
        ks = FIELD_KEY_W'($urandom);
        // small key space gives collisions in a bucket
        if ($urandom_range(1)) begin
            kf = FIELD_KEY_W'($urandom_range(7));
            ks = FIELD_KEY_W'($urandom_range(40));
        end
        if (used_first.size() > 0 && $urandom_range(1)) begin
            k = $urandom_range(used_first.size() - 1);
            kf = used_first[k];
            ks = used_second[k];
        end
        if (sel < 35) send_op(FUNC_UPSERT, kf, ks, $urandom);
        else if (sel < 70) send_op(FUNC_LOOKUP, kf, ks, $urandom);
        else if (sel < 98) send_op(FUNC_INSERT, kf, ks, $urandom);
        else begin
            send_op(FUNC_CLEAR, kf, ks, $urandom);
            used_first.delete();
            used_second.delete();
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes, every operation, shadowing, clear
        send_op(FUNC_LOOKUP, '0, '0, '0);
        send_op(FUNC_UPSERT, '0, '0, 32'h7fffffff);
        send_op(FUNC_UPSERT, '0, '0, 32'h80000000);
        send_op(FUNC_LOOKUP, '0, '0, '0);
        send_op(FUNC_UPSERT, '1, '1, 32'hffffffff);
        send_op(FUNC_LOOKUP, '1, '1, '0);
        send_op(FUNC_INSERT, '1, '1, 32'h12345678);
        send_op(FUNC_LOOKUP, '1, '1, '0);
        send_op(FUNC_INSERT, 20'd1, 20'd0, 32'h1);
        send_op(FUNC_INSERT, 20'd0, 20'd31, 32'h2);
        send_op(FUNC_LOOKUP, 20'd1, 20'd0, '0);
        send_op(FUNC_LOOKUP, 20'd0, 20'd31, '0);
        send_op(FUNC_UPSERT, 20'haaaaa, 20'h55555, 32'h5555aaaa);
        send_op(FUNC_LOOKUP, 20'h55555, 20'haaaaa, '0);
        send_op(FUNC_CLEAR, '1, '1, '1);
        send_op(FUNC_LOOKUP, '0, '0, '0);
        send_op(FUNC_LOOKUP, '1, '1, '0);

        // fill the store: 1024 appends, then dropped appends flag full
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 1024; i++) begin
            if (i == 100) hold_off_req <= ~hold_off_req;
            send_op(FUNC_INSERT, i[19:0], 20'(i * 7), $urandom);
        end
        send_op(FUNC_INSERT, 20'd5, 20'd5, 32'h1);
        send_op(FUNC_UPSERT, 20'hfffff, 20'h0, 32'h2);
        send_op(FUNC_UPSERT, 20'd3, 20'd21, 32'h3);
        send_op(FUNC_LOOKUP, 20'd3, 20'd21, '0);
        send_op(FUNC_CLEAR, '0, '0, '0);
        used_first.delete();
        used_second.delete();

        // random phases with changing idle patterns
        send_idle_pct = 6;
        recv_idle_pct = 54;
        repeat (68) random_op();
        send_idle_pct = 54;
        recv_idle_pct = 6;
        repeat (68) random_op();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (68) random_op();

        drain_results();
        if (fail_count == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/pkchm_pkg.sv
design/pkchm_ram.sv
design/pair_key_chained_hash_map_core.sv
design/pkchm_checker.sv
verif/pair_key_chained_hash_map_core_checker.sv
verif/pair_key_chained_hash_map_core_tb.sv
